/* rtl/bsfc_pkg.sv */
`default_nettype none
package bsfc_pkg;

    localparam int DATA_W  = 32;
    localparam int RAD_W   = 31;
    localparam int COEF_W  = 16;
    localparam int SLOPE_W = 16;
    localparam int COL_W   = 64;
    localparam int PROD_W  = DATA_W + COEF_W;        // 48
    localparam int ACC_W   = PROD_W + 2;             // 50, three products summed
    localparam int SHR_W   = 37;                     // pre-saturation width
    localparam int BPROD_W = DATA_W + SLOPE_W + 1;   // 49
    localparam int XFM_SHR = 14;
    localparam int BND_SHR = 12;
    localparam int IDX_W   = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CULL_MASK = 3'd0;
    localparam logic [IDX_W-1:0] REG_NEAR_Z    = 3'd1;
    localparam logic [IDX_W-1:0] REG_FAR_Z     = 3'd2;
    localparam logic [IDX_W-1:0] REG_X_SLOPE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_SLOPE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_COL_X     = 3'd5;
    localparam logic [IDX_W-1:0] REG_COL_Y     = 3'd6;
    localparam logic [IDX_W-1:0] REG_COL_Z     = 3'd7;

    // reset values
    localparam logic [2:0]         RST_CULL_MASK = 3'd7;
    localparam logic [DATA_W-1:0]  RST_NEAR_Z    = 32'd65536;
    localparam logic [DATA_W-1:0]  RST_FAR_Z     = 32'd65536000;
    localparam logic [SLOPE_W-1:0] RST_X_SLOPE   = 16'd4096;
    localparam logic [SLOPE_W-1:0] RST_Y_SLOPE   = 16'd4096;
    localparam logic [COL_W-1:0]   RST_COL_X     = 64'h0000_0000_0000_4000;
    localparam logic [COL_W-1:0]   RST_COL_Y     = 64'h0000_0000_4000_0000;
    localparam logic [COL_W-1:0]   RST_COL_Z     = 64'h0000_4000_0000_0000;

    // mask bits
    localparam int MASK_Z  = 0;
    localparam int MASK_LR = 1;
    localparam int MASK_TB = 2;

    // cull reasons
    localparam logic [1:0] REASON_NONE = 2'd0;
    localparam logic [1:0] REASON_Z    = 2'd1;
    localparam logic [1:0] REASON_LR   = 2'd2;
    localparam logic [1:0] REASON_TB   = 2'd3;

    typedef struct packed {
        logic mul;
        logic sum;
        logic xfm;
        logic bmul;
        logic bsat;
        logic out;
    } t_pipe_en;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic [RAD_W-1:0]         rad;
    } t_cam;

    typedef struct packed {
        t_cam                     cam;
        logic signed [DATA_W-1:0] ztx;
        logic signed [DATA_W-1:0] zty;
        logic                     zfail;
    } t_bnd;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
        logic [SHR_W-DATA_W:0] top;
        top = v[SHR_W-1:DATA_W-1];
        if ((&top) || (~|top))
            sat32 = v[DATA_W-1:0];
        else if (v[SHR_W-1])
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

endpackage
`default_nettype wire

/* rtl/bsfc_xform.sv */
`default_nettype none
module bsfc_xform
    import bsfc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_pipe_en                 i_en,
    input  wire logic signed [DATA_W-1:0] i_wx,
    input  wire logic signed [DATA_W-1:0] i_wy,
    input  wire logic signed [DATA_W-1:0] i_wz,
    input  wire logic [RAD_W-1:0]         i_rad,
    input  wire logic [COL_W-1:0]         i_col_x,
    input  wire logic [COL_W-1:0]         i_col_y,
    input  wire logic [COL_W-1:0]         i_col_z,
    output t_cam                          o_cam
);

    logic [COL_W-1:0]         col   [3];
    logic signed [DATA_W-1:0] world [3];

    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [PROD_W-1:0] n_prod [3][3];
    logic [RAD_W-1:0]         r_rad_mul;
    logic signed [ACC_W-1:0]  r_acc [3];
    logic signed [ACC_W-1:0]  n_acc [3];
    logic [RAD_W-1:0]         r_rad_sum;
    logic signed [DATA_W-1:0] n_pos [3];
    t_cam                     r_cam;

    assign col[0]   = i_col_x;
    assign col[1]   = i_col_y;
    assign col[2]   = i_col_z;
    assign world[0] = i_wx;
    assign world[1] = i_wy;
    assign world[2] = i_wz;

    // stage 1: nine 32x16 products
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[a][k] = world[k] * $signed(col[a][COEF_W*k +: COEF_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_prod    <= n_prod;
            r_rad_mul <= i_rad;
        end
    end

    // stage 2: exact dot product per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_acc[a] = ACC_W'(r_prod[a][0]) + ACC_W'(r_prod[a][1]) + ACC_W'(r_prod[a][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_acc     <= n_acc;
            r_rad_sum <= r_rad_mul;
        end
    end

    // stage 3: floor shift to Q16.16, add whole-unit translation, saturate
    always_comb begin
        logic [SHR_W-1:0] tot;
        logic [COEF_W-1:0] t;
        for (int a = 0; a < 3; a++) begin
            t   = col[a][COL_W-1 -: COEF_W];
            tot = {r_acc[a][ACC_W-1], r_acc[a][ACC_W-1:XFM_SHR]}
                + {{(SHR_W-DATA_W){t[COEF_W-1]}}, t, {(DATA_W-COEF_W){1'b0}}};
            n_pos[a] = sat32($signed(tot));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.xfm) begin
            r_cam.px  <= n_pos[0];
            r_cam.py  <= n_pos[1];
            r_cam.pz  <= n_pos[2];
            r_cam.rad <= r_rad_sum;
        end
    end

    assign o_cam = r_cam;

endmodule
`default_nettype wire

/* rtl/bsfc_bound.sv */
`default_nettype none
module bsfc_bound
    import bsfc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_pipe_en                 i_en,
    input  wire t_cam                     i_cam,
    input  wire logic [SLOPE_W-1:0]       i_x_slope,
    input  wire logic [SLOPE_W-1:0]       i_y_slope,
    input  wire logic signed [DATA_W-1:0] i_near_z,
    input  wire logic signed [DATA_W-1:0] i_far_z,
    output t_bnd                          o_bnd
);

    logic signed [SLOPE_W:0]    sx;
    logic signed [SLOPE_W:0]    sy;
    logic signed [BPROD_W-1:0]  n_bx;
    logic signed [BPROD_W-1:0]  n_by;
    logic signed [DATA_W+1:0]   z_lo;
    logic signed [DATA_W+1:0]   z_hi;
    logic signed [DATA_W+1:0]   far_ext;
    logic signed [DATA_W+1:0]   near_ext;
    logic                       n_zfail;

    logic signed [BPROD_W-1:0]  r_bx;
    logic signed [BPROD_W-1:0]  r_by;
    logic                       r_zfail_m;
    t_cam                       r_cam_m;
    t_bnd                       r_bnd;

    // stage 4: slope * z products, z planes checked in parallel
    assign sx   = {1'b0, i_x_slope};
    assign sy   = {1'b0, i_y_slope};
    assign n_bx = sx * i_cam.pz;
    assign n_by = sy * i_cam.pz;

    assign z_lo     = {{2{i_cam.pz[DATA_W-1]}}, i_cam.pz} - {3'b000, i_cam.rad};
    assign z_hi     = {{2{i_cam.pz[DATA_W-1]}}, i_cam.pz} + {3'b000, i_cam.rad};
    assign far_ext  = {{2{i_far_z[DATA_W-1]}}, i_far_z};
    assign near_ext = {{2{i_near_z[DATA_W-1]}}, i_near_z};
    assign n_zfail  = (z_lo > far_ext) || (z_hi < near_ext);

    always_ff @(posedge i_clk) begin
        if (i_en.bmul) begin
            r_bx      <= n_bx;
            r_by      <= n_by;
            r_zfail_m <= n_zfail;
            r_cam_m   <= i_cam;
        end
    end

    // stage 5: Q20.28 -> Q16.16 with floor, saturate
    always_ff @(posedge i_clk) begin
        if (i_en.bsat) begin
            r_bnd.ztx   <= sat32(r_bx[BPROD_W-1:BND_SHR]);
            r_bnd.zty   <= sat32(r_by[BPROD_W-1:BND_SHR]);
            r_bnd.zfail <= r_zfail_m;
            r_bnd.cam   <= r_cam_m;
        end
    end

    assign o_bnd = r_bnd;

endmodule
`default_nettype wire

/* rtl/bsfc_test.sv */
`default_nettype none
module bsfc_test
    import bsfc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_pipe_en   i_en,
    input  wire t_bnd       i_bnd,
    input  wire logic [2:0] i_cull_mask,
    output logic            o_visible,
    output logic [1:0]      o_reason
);

    logic signed [DATA_W+1:0] x_lo;
    logic signed [DATA_W+1:0] x_hi;
    logic signed [DATA_W+1:0] y_lo;
    logic signed [DATA_W+1:0] y_hi;
    logic signed [DATA_W+1:0] ztx_p;
    logic signed [DATA_W+1:0] ztx_n;
    logic signed [DATA_W+1:0] zty_p;
    logic signed [DATA_W+1:0] zty_n;
    logic                     lr_fail;
    logic                     tb_fail;
    logic [1:0]               n_reason;
    logic                     r_visible;
    logic [1:0]               r_reason;

    assign x_lo  = {{2{i_bnd.cam.px[DATA_W-1]}}, i_bnd.cam.px} - {3'b000, i_bnd.cam.rad};
    assign x_hi  = {{2{i_bnd.cam.px[DATA_W-1]}}, i_bnd.cam.px} + {3'b000, i_bnd.cam.rad};
    assign y_lo  = {{2{i_bnd.cam.py[DATA_W-1]}}, i_bnd.cam.py} - {3'b000, i_bnd.cam.rad};
    assign y_hi  = {{2{i_bnd.cam.py[DATA_W-1]}}, i_bnd.cam.py} + {3'b000, i_bnd.cam.rad};
    assign ztx_p = {{2{i_bnd.ztx[DATA_W-1]}}, i_bnd.ztx};
    assign zty_p = {{2{i_bnd.zty[DATA_W-1]}}, i_bnd.zty};
    assign ztx_n = -ztx_p;
    assign zty_n = -zty_p;

    // negative z gives a negative bound; compared as is
    assign lr_fail = (x_lo > ztx_p) || (x_hi < ztx_n);
    assign tb_fail = (y_lo > zty_p) || (y_hi < zty_n);

    // first failing test in z, left/right, top/bottom order wins
    always_comb begin
        n_reason = REASON_NONE;
        if (i_cull_mask[MASK_Z] && i_bnd.zfail)
            n_reason = REASON_Z;
        else if (i_cull_mask[MASK_LR] && lr_fail)
            n_reason = REASON_LR;
        else if (i_cull_mask[MASK_TB] && tb_fail)
            n_reason = REASON_TB;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.out) begin
            r_reason  <= n_reason;
            r_visible <= (n_reason == REASON_NONE);
        end
    end

    assign o_visible = r_visible;
    assign o_reason  = r_reason;

endmodule
`default_nettype wire

/* rtl/bounding_sphere_frustum_cull.sv */
// Bounding-sphere view-frustum cull.
// Input stream (i_s_*): one word per object; tdata holds centre_x, centre_y,
// centre_z (signed Q16.16) and radius (31-bit Q16.16), lowest bits first.
// Output stream (o_m_*): one word per object, in order; tdata bit 0 is
// visible, bits 2:1 the cull reason (0 none, 1 z planes, 2 left/right,
// 3 top/bottom).
// Configuration over the APB port, 64-bit data, register i at byte 8*i;
// write only while no object is in flight.
// Pipeline: six registered stages from acceptance to o_m_tvalid: products,
// dot-product sum, translate/saturate, slope products, bound saturate, plane compare.
// Throughput: one object per cycle while o_s_tready is high; each stage has its own valid bit.
// Stall: when i_m_tready is low the output word holds; stages behind it keep
// filling bubbles, and o_s_tready drops only once all six stages hold a word.
// Reset: all valid bits clear and the registers return to an identity
// transform, near 1.0, far 1000.0, slopes 1.0, all tests enabled.
`default_nettype none
module bounding_sphere_frustum_cull
    import bsfc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // stream in
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // centre_x, centre_y, centre_z, radius, pad
    // stream out
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [7:0]        o_m_tdata,   // visible, cull_reason[1:0], pad
    // APB
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [2:0]               r_cull_mask;
    logic signed [DATA_W-1:0] r_near_z;
    logic signed [DATA_W-1:0] r_far_z;
    logic [SLOPE_W-1:0]       r_x_slope;
    logic [SLOPE_W-1:0]       r_y_slope;
    logic [COL_W-1:0]         r_col_x;
    logic [COL_W-1:0]         r_col_y;
    logic [COL_W-1:0]         r_col_z;

    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_wr;

    t_pipe_en r_vld;
    t_pipe_en en;
    t_cam     cam;
    t_bnd     bnd;
    logic     visible;
    logic [1:0] reason;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_mask <= RST_CULL_MASK;
            r_near_z    <= RST_NEAR_Z;
            r_far_z     <= RST_FAR_Z;
            r_x_slope   <= RST_X_SLOPE;
            r_y_slope   <= RST_Y_SLOPE;
            r_col_x     <= RST_COL_X;
            r_col_y     <= RST_COL_Y;
            r_col_z     <= RST_COL_Z;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CULL_MASK: r_cull_mask <= pwdata[2:0];
                REG_NEAR_Z:    r_near_z    <= pwdata[DATA_W-1:0];
                REG_FAR_Z:     r_far_z     <= pwdata[DATA_W-1:0];
                REG_X_SLOPE:   r_x_slope   <= pwdata[SLOPE_W-1:0];
                REG_Y_SLOPE:   r_y_slope   <= pwdata[SLOPE_W-1:0];
                REG_COL_X:     r_col_x     <= pwdata;
                REG_COL_Y:     r_col_y     <= pwdata;
                REG_COL_Z:     r_col_z     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CULL_MASK: prdata = {61'd0, r_cull_mask};
            REG_NEAR_Z:    prdata = {32'd0, r_near_z};
            REG_FAR_Z:     prdata = {32'd0, r_far_z};
            REG_X_SLOPE:   prdata = {48'd0, r_x_slope};
            REG_Y_SLOPE:   prdata = {48'd0, r_y_slope};
            REG_COL_X:     prdata = r_col_x;
            REG_COL_Y:     prdata = r_col_y;
            REG_COL_Z:     prdata = r_col_z;
            default:       prdata = 64'd0;
        endcase
    end

    // a stage loads when it is empty or its word moves on
    always_comb begin
        en.out  = !r_vld.out  || i_m_tready;
        en.bsat = !r_vld.bsat || en.out;
        en.bmul = !r_vld.bmul || en.bsat;
        en.xfm  = !r_vld.xfm  || en.bmul;
        en.sum  = !r_vld.sum  || en.xfm;
        en.mul  = !r_vld.mul  || en.sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en.mul)  r_vld.mul  <= i_s_tvalid;
            if (en.sum)  r_vld.sum  <= r_vld.mul;
            if (en.xfm)  r_vld.xfm  <= r_vld.sum;
            if (en.bmul) r_vld.bmul <= r_vld.xfm;
            if (en.bsat) r_vld.bsat <= r_vld.bmul;
            if (en.out)  r_vld.out  <= r_vld.bsat;
        end
    end

    assign o_s_tready = en.mul;

    bsfc_xform u_xform (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_wx    (i_s_tdata[31:0]),
        .i_wy    (i_s_tdata[63:32]),
        .i_wz    (i_s_tdata[95:64]),
        .i_rad   (i_s_tdata[126:96]),
        .i_col_x (r_col_x),
        .i_col_y (r_col_y),
        .i_col_z (r_col_z),
        .o_cam   (cam)
    );

    bsfc_bound u_bound (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_cam     (cam),
        .i_x_slope (r_x_slope),
        .i_y_slope (r_y_slope),
        .i_near_z  (r_near_z),
        .i_far_z   (r_far_z),
        .o_bnd     (bnd)
    );

    bsfc_test u_test (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_bnd       (bnd),
        .i_cull_mask (r_cull_mask),
        .o_visible   (visible),
        .o_reason    (reason)
    );

    assign o_m_tvalid = r_vld.out;
    assign o_m_tdata  = {5'd0, reason, visible};

    // visible flag agrees with the reason code
    a_vis_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tdata[2:1] == REASON_NONE)))
        else $error("visible flag disagrees with cull reason");

    // input is only refused when every stage holds a word
    a_ready_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld != 6'b111111) |-> o_s_tready)
        else $error("input stalled while pipeline has a bubble");

    // a word reaching the output came from a valid word one stage earlier
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_vld.bsat))
        else $error("output valid without a word in the bound stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule
`default_nettype wire
